FILE: src/eavf_pkg.sv
// Types and constants shared by the encoder angle and velocity filter.
// No dependencies; every other file of the block imports this package.
package eavf_pkg;

    localparam int RAW_W      = 12;
    localparam int ANGLE_W    = 16;
    localparam int TIME_W     = 48;
    localparam int VEL_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int DB_W       = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam int NUMER_W    = 49;
    localparam int QUOT_W     = 36;
    localparam int DIV_CNT_W  = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(QUOT_W);

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_DB   = 2'd2;

    localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST    = 16'd16384;
    localparam logic [GAIN_W-1:0] VELOCITY_GAIN_RST = 16'd6554;

    localparam logic signed [21:0] US_PER_S  = 22'sd1000000;
    localparam logic [VEL_W-2:0]   VEL_LIM   = '1;

    typedef struct packed {
        logic                start;
        logic [NUMER_W-1:0]  numer;
        logic [TIME_W-1:0]   denom;
    } eavf_div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
    } eavf_div_rsp_t;

endpackage

FILE: src/eavf_if.sv
// Handshake interfaces for the sample and result channels of the filter.
// Depends on eavf_pkg for the field widths.
interface eavf_sample_if
    import eavf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic              read_ok;
    logic [RAW_W-1:0]  enc_angle;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, command, read_ok, enc_angle, time_us, input ready);
    modport sink   (input valid, command, read_ok, enc_angle, time_us, output ready);
endinterface

interface eavf_result_if
    import eavf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ANGLE_W-1:0]      filtered_angle;
    logic signed [VEL_W-1:0] filtered_velocity;

    modport source (output valid, filtered_angle, filtered_velocity, input ready);
    modport sink   (input valid, filtered_angle, filtered_velocity, output ready);
endinterface

FILE: src/eavf_div.sv
// Restoring divider, one quotient bit per cycle, for the velocity estimate.
// Depends on eavf_pkg; the quotient is known to fit in QUOT_W bits.
module eavf_div
    import eavf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  eavf_div_req_t req,
    output eavf_div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    den_reg;
    logic [QUOT_W-1:0]    sh_reg;
    logic [TIME_W:0]      trial;

    assign trial = {rem_reg, sh_reg[QUOT_W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {{(TIME_W-(NUMER_W-QUOT_W)){1'b0}}, req.numer[NUMER_W-1:QUOT_W]};
            sh_reg  <= req.numer[QUOT_W-1:0];
            den_reg <= req.denom;
        end
        else if (busy_reg)
        begin
            if (!trial[TIME_W])
            begin
                rem_reg <= trial[TIME_W-1:0];
            end
            else
            begin
                rem_reg <= {rem_reg[TIME_W-2:0], sh_reg[QUOT_W-1]};
            end
            sh_reg <= {sh_reg[QUOT_W-2:0], ~trial[TIME_W]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sh_reg;

endmodule

FILE: src/encoder_angle_velocity_filter_core.sv
// Channel   Direction  Word
// sample    in         command, read_ok, enc_angle, time_us
// result    out        filtered_angle, filtered_velocity
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// A failed read or a load goes from acceptance through the output step back to idle.
// An update without a usable elapsed time runs the angle product and share, then the output step;
// a full update also runs the 36-step restoring divider that forms the instantaneous velocity.
// One multiplier is shared by the angle, scaling and velocity products.
// Reset clears the estimates and loads the register defaults; a stalled result holds
// the block in its output step until the word is taken.
module encoder_angle_velocity_filter_core
    import eavf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    eavf_sample_if.sink           sample,
    eavf_result_if.source         result
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MULA  = 4'd1;
    localparam logic [3:0] ST_SHARE = 4'd2;
    localparam logic [3:0] ST_MULS  = 4'd3;
    localparam logic [3:0] ST_DIVST = 4'd4;
    localparam logic [3:0] ST_DIVW  = 4'd5;
    localparam logic [3:0] ST_DIFF  = 4'd6;
    localparam logic [3:0] ST_MULV  = 4'd7;
    localparam logic [3:0] ST_VUPD  = 4'd8;
    localparam logic [3:0] ST_DEAD  = 4'd9;
    localparam logic [3:0] ST_WRITE = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [GAIN_W-1:0]       angle_gain_reg;
    logic [GAIN_W-1:0]       velocity_gain_reg;
    logic [DB_W-1:0]         velocity_db_reg;
    logic [ANGLE_W-1:0]      angle_est_reg;
    logic signed [VEL_W-1:0] vel_est_reg;
    logic [TIME_W-1:0]       last_time_reg;
    logic                    out_valid_reg;

    logic [RAW_W-1:0]        raw_reg;
    logic [TIME_W-1:0]       time_reg;
    logic signed [55:0]      prod_reg;
    logic signed [16:0]      share_reg;
    logic [TIME_W-1:0]       dt_reg;
    logic [QUOT_W-1:0]       q_reg;
    logic signed [VEL_W:0]   diff_reg;
    logic signed [VEL_W-1:0] v_reg;
    logic [ANGLE_W-1:0]      out_angle_reg;
    logic signed [VEL_W-1:0] out_vel_reg;

    logic                    accept;
    logic                    out_free;
    logic [ANGLE_W-1:0]      delta;
    logic signed [33:0]      mul_a;
    logic signed [21:0]      mul_b;
    logic signed [33:0]      sh_sum;
    logic signed [16:0]      share_c;
    logic [TIME_W:0]         dt_full;
    logic                    time_ok;
    logic signed [16:0]      share_abs;
    logic [VEL_W-2:0]        q_sat;
    logic signed [VEL_W-1:0] inst;
    logic signed [48:0]      v_sum;
    logic signed [34:0]      v_new;
    logic signed [VEL_W-1:0] v_sat;
    logic signed [VEL_W-1:0] v_abs;
    logic                    in_deadband;
    eavf_div_req_t           div_req;
    eavf_div_rsp_t           div_rsp;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign sample.ready             = (state_reg == ST_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.filtered_angle    = out_angle_reg;
    assign result.filtered_velocity = out_vel_reg;

    assign delta     = {raw_reg, 4'b0000} - angle_est_reg;
    assign sh_sum    = prod_reg[33:0] + 34'sd16384;
    assign share_c   = sh_sum[31:15];
    assign dt_full   = {1'b0, time_reg} - {1'b0, last_time_reg};
    assign time_ok   = (last_time_reg != '0) && !dt_full[TIME_W] && (dt_full[TIME_W-1:0] != '0);
    assign share_abs = share_reg[16] ? -share_reg : share_reg;
    assign q_sat     = (|q_reg[QUOT_W-1:VEL_W-1]) ? VEL_LIM : q_reg[VEL_W-2:0];
    assign inst      = share_reg[16] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    assign v_sum     = prod_reg[48:0] + 49'sd16384;
    assign v_new     = 35'(vel_est_reg) + 35'($signed(v_sum[48:15]));
    assign v_abs     = v_reg[VEL_W-1] ? -v_reg : v_reg;
    assign in_deadband = (v_abs[VEL_W-2:0] < velocity_db_reg);

    always_comb
    begin
        if (v_new > 35'sd2147483647)
        begin
            v_sat = $signed({1'b0, VEL_LIM});
        end
        else if (v_new < -35'sd2147483647)
        begin
            v_sat = -$signed({1'b0, VEL_LIM});
        end
        else
        begin
            v_sat = v_new[VEL_W-1:0];
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_MULA:
            begin
                mul_a = 34'($signed(delta));
                mul_b = $signed({6'b0, angle_gain_reg});
            end
            ST_MULS:
            begin
                mul_a = $signed({18'b0, share_abs[15:0]});
                mul_b = US_PER_S;
            end
            ST_MULV:
            begin
                mul_a = 34'(diff_reg);
                mul_b = $signed({6'b0, velocity_gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_req.start = (state_reg == ST_DIVST);
    assign div_req.numer = {13'b0, prod_reg[QUOT_W-1:0]} + {2'b0, dt_reg[TIME_W-1:1]};
    assign div_req.denom = dt_reg;

    eavf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample.read_ok && sample.command == CMD_UPDATE)
                    begin
                        state_next = ST_MULA;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_MULA:  state_next = ST_SHARE;
            ST_SHARE: state_next = time_ok ? ST_MULS : ST_WRITE;
            ST_MULS:  state_next = ST_DIVST;
            ST_DIVST: state_next = ST_DIVW;
            ST_DIVW:  state_next = div_rsp.done ? ST_DIFF : ST_DIVW;
            ST_DIFF:  state_next = ST_MULV;
            ST_MULV:  state_next = ST_VUPD;
            ST_VUPD:  state_next = ST_DEAD;
            ST_DEAD:  state_next = ST_WRITE;
            ST_WRITE: state_next = out_free ? ST_IDLE : ST_WRITE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            angle_gain_reg    <= ANGLE_GAIN_RST;
            velocity_gain_reg <= VELOCITY_GAIN_RST;
            velocity_db_reg   <= '0;
            angle_est_reg     <= '0;
            vel_est_reg       <= '0;
            last_time_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ANGLE_GAIN:    angle_gain_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_VELOCITY_GAIN: velocity_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_VELOCITY_DB:   velocity_db_reg   <= cfg_data[DB_W-1:0];
                    default:           ;
                endcase
            end

            if (accept && sample.read_ok && sample.command == CMD_LOAD)
            begin
                angle_est_reg <= {sample.enc_angle, 4'b0000};
                last_time_reg <= sample.time_us;
            end

            if (state_reg == ST_SHARE)
            begin
                angle_est_reg <= angle_est_reg + share_c[ANGLE_W-1:0];
                last_time_reg <= time_reg;
            end

            if (state_reg == ST_DEAD)
            begin
                vel_est_reg <= in_deadband ? '0 : v_reg;
            end

            if (state_reg == ST_WRITE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg  <= sample.enc_angle;
            time_reg <= sample.time_us;
        end
        if (state_reg == ST_MULA || state_reg == ST_MULS || state_reg == ST_MULV)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_SHARE)
        begin
            share_reg <= share_c;
            dt_reg    <= dt_full[TIME_W-1:0];
        end
        if (state_reg == ST_DIVW && div_rsp.done)
        begin
            q_reg <= div_rsp.quot;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= 33'(inst) - 33'(vel_est_reg);
        end
        if (state_reg == ST_VUPD)
        begin
            v_reg <= v_sat;
        end
        if (state_reg == ST_WRITE && out_free)
        begin
            out_angle_reg <= angle_est_reg;
            out_vel_reg   <= vel_est_reg;
        end
    end

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIVW)
        else $error("Divider finished outside its wait step.");

    a_vel_never_min: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.filtered_velocity != 32'sh8000_0000)
        else $error("Velocity word holds the most negative value.");

    a_failed_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !sample.read_ok |=>
            $stable(angle_est_reg) && $stable(vel_est_reg) && $stable(last_time_reg))
        else $error("A failed read changed the estimates.");

    a_load_sets_angle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sample.read_ok && sample.command == CMD_LOAD |=>
            angle_est_reg == {$past(sample.enc_angle), 4'b0000} && $stable(vel_est_reg))
        else $error("A load did not set the angle or disturbed the velocity.");

    a_write_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("Result word was not offered after the output step.");
`endif

endmodule
